>>> hw/rtl/ctbe_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ctbe_pkg
// Shared types and constants of the cursor text buffer editor.
// ---------------------------------------------------------------------------
package ctbe_pkg;

  // text capacity in characters (2 .. 64)
  localparam int unsigned TEXT_DEPTH = 64;
  // address bits of the text and clipboard stores
  localparam int unsigned AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  // width of counts, cursor and lengths
  localparam int unsigned CW = 7;

  // command codes
  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_INSERT = 3'd2,
    OP_CUT    = 3'd3,
    OP_COPY   = 3'd4,
    OP_PASTE  = 3'd5,
    OP_READ   = 3'd6
  } opcode_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SHR_RD,
    S_SHR_WR,
    S_FILL_RD,
    S_FILL_WR,
    S_GRAB_RD,
    S_GRAB_WR,
    S_SHL_RD,
    S_SHL_WR,
    S_READ_RD,
    S_READ_OUT,
    S_STATUS
  } state_e;

  // one result item
  typedef struct packed {
    logic          is_char;
    logic [7:0]    out_char;
    logic          last;
    logic [CW-1:0] text_length;
    logic [CW-1:0] cursor_pos;
    logic          overflow;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/ctbe_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ctbe_out_buf
// Single output register that decouples the sequencer from the result sink.
// ---------------------------------------------------------------------------
module ctbe_out_buf
  import ctbe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // room when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload load
  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("result pushed into a full output register");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_o)))
    else $error("stalled result changed");
  a_transfer_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !push_i) |=> !out_valid_o)
    else $error("taken result not released");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ctbe_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ctbe_engine
// Command sequencer with text and clipboard stores and one shared address
// adder; each character passes through a read state and then a write or output state.
// ---------------------------------------------------------------------------
module ctbe_engine
  import ctbe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    opcode_i,
  input  wire logic [7:0]    character_i,
  input  wire logic [CW-1:0] count_i,
  input  wire logic          buf_ready_i,
  output logic               push_o,
  output result_t            res_o
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TEXT_DEPTH);

  // stores
  logic [7:0] text_mem [TEXT_DEPTH];
  logic [7:0] clip_mem [TEXT_DEPTH];
  logic [7:0] text_rdata_q;
  logic [7:0] clip_rdata_q;

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] text_cnt_q, text_cnt_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] clip_cnt_q, clip_cnt_d;

  // command payload and loop registers
  opcode_e       op_q;
  logic [7:0]    ch_q;
  logic [CW-1:0] amt_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] sum_q;
  logic          ovf_q;

  logic          accept;
  opcode_e       op_in;
  logic [CW-1:0] avail, take, room, paste_amt, ins_amt;
  logic          full, ins_none, ins_ovf;
  logic [CW-1:0] idx_inc, sum_inc;
  logic          fill_last, grab_last, shl_last, read_last, cut_tail;

  // shared adder
  logic [CW-1:0] add_a, add_b, sum;

  logic          text_we, clip_we;
  logic [AW-1:0] text_waddr, text_raddr, clip_waddr, clip_raddr;
  logic [7:0]    text_wdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign op_in      = opcode_e'(opcode_i);

  // command setup arithmetic
  always_comb begin
    avail     = text_cnt_q - cursor_q;
    take      = (count_i < avail) ? count_i : avail;
    room      = DEPTH_C - text_cnt_q;
    paste_amt = (clip_cnt_q < room) ? clip_cnt_q : room;
    full      = (text_cnt_q >= DEPTH_C);
    ins_amt   = (op_in == OP_PASTE) ? paste_amt : CW'(1);
    ins_none  = (op_in == OP_PASTE) ? (paste_amt == '0) : full;
    ins_ovf   = (op_in == OP_PASTE) ? (clip_cnt_q > room) : full;
  end

  // loop end tests
  assign idx_inc   = idx_q + CW'(1);
  assign sum_inc   = sum_q + CW'(1);
  assign fill_last = (idx_inc == amt_q);
  assign grab_last = fill_last;
  assign shl_last  = (sum_inc >= text_cnt_q);
  assign read_last = (idx_inc == text_cnt_q);
  assign cut_tail  = (amt_q < (text_cnt_q - cursor_q));

  // shared adder operand select
  always_comb begin
    add_a = idx_q;
    add_b = '0;
    unique case (state_q)
      S_SHR_WR, S_SHL_RD:   add_b = amt_q;
      S_FILL_WR, S_GRAB_RD: add_b = cursor_q;
      default:              add_b = '0;
    endcase
  end
  assign sum = add_a + add_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_INSERT, OP_PASTE: begin
              if (ins_none) begin
                state_d = S_STATUS;
              end else if (text_cnt_q > cursor_q) begin
                state_d = S_SHR_RD;
              end else begin
                state_d = S_FILL_RD;
              end
            end
            OP_CUT, OP_COPY: state_d = (take == '0) ? S_STATUS : S_GRAB_RD;
            OP_READ:         state_d = (text_cnt_q == '0) ? S_STATUS : S_READ_RD;
            default:         state_d = S_STATUS;
          endcase
        end
      end
      S_SHR_RD:  state_d = S_SHR_WR;
      S_SHR_WR:  state_d = (idx_q == cursor_q) ? S_FILL_RD : S_SHR_RD;
      S_FILL_RD: state_d = S_FILL_WR;
      S_FILL_WR: state_d = fill_last ? S_STATUS : S_FILL_RD;
      S_GRAB_RD: state_d = S_GRAB_WR;
      S_GRAB_WR: begin
        if (!grab_last) begin
          state_d = S_GRAB_RD;
        end else if (op_q == OP_CUT && cut_tail) begin
          state_d = S_SHL_RD;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_SHL_RD:   state_d = S_SHL_WR;
      S_SHL_WR:   state_d = shl_last ? S_STATUS : S_SHL_RD;
      S_READ_RD:  state_d = S_READ_OUT;
      S_READ_OUT: begin
        if (buf_ready_i) begin
          state_d = read_last ? S_IDLE : S_READ_RD;
        end
      end
      S_STATUS: begin
        if (buf_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // store control and result outputs
  always_comb begin
    text_we    = 1'b0;
    clip_we    = 1'b0;
    text_waddr = sum[AW-1:0];
    text_wdata = text_rdata_q;
    text_raddr = idx_q[AW-1:0];
    clip_waddr = idx_q[AW-1:0];
    clip_raddr = idx_q[AW-1:0];
    push_o     = 1'b0;
    res_o      = '{is_char: 1'b0, out_char: 8'd0, last: 1'b1,
                   text_length: text_cnt_q, cursor_pos: cursor_q,
                   overflow: ovf_q};
    unique case (state_q)
      S_SHR_WR: text_we = 1'b1;
      S_FILL_WR: begin
        text_we    = 1'b1;
        text_wdata = (op_q == OP_INSERT) ? ch_q : clip_rdata_q;
      end
      S_GRAB_RD: text_raddr = sum[AW-1:0];
      S_GRAB_WR: clip_we = 1'b1;
      S_SHL_RD:  text_raddr = sum[AW-1:0];
      S_SHL_WR: begin
        text_we    = 1'b1;
        text_waddr = idx_q[AW-1:0];
      end
      S_READ_OUT: begin
        push_o = buf_ready_i;
        res_o  = '{is_char: 1'b1, out_char: text_rdata_q, last: read_last,
                   text_length: text_cnt_q, cursor_pos: cursor_q,
                   overflow: 1'b0};
      end
      S_STATUS: push_o = buf_ready_i;
      default: ;
    endcase
  end

  // count, cursor and clipboard length updates
  always_comb begin
    text_cnt_d = text_cnt_q;
    cursor_d   = cursor_q;
    clip_cnt_d = clip_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_LEFT: begin
              if (cursor_q != '0) cursor_d = cursor_q - CW'(1);
            end
            OP_RIGHT: begin
              if (cursor_q < text_cnt_q) cursor_d = cursor_q + CW'(1);
            end
            OP_CUT, OP_COPY: clip_cnt_d = take;
            default: ;
          endcase
        end
      end
      S_FILL_WR: begin
        if (fill_last) begin
          cursor_d   = cursor_q + amt_q;
          text_cnt_d = text_cnt_q + amt_q;
        end
      end
      S_GRAB_WR: begin
        if (grab_last && op_q == OP_CUT && !cut_tail) begin
          text_cnt_d = text_cnt_q - amt_q;
        end
      end
      S_SHL_WR: begin
        if (shl_last) text_cnt_d = text_cnt_q - amt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      text_cnt_q <= '0;
      cursor_q   <= '0;
      clip_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      text_cnt_q <= text_cnt_d;
      cursor_q   <= cursor_d;
      clip_cnt_q <= clip_cnt_d;
    end
  end

  // command latch and loop index
  always_ff @(posedge clk_i) begin
    if (state_q == S_SHL_RD) begin
      sum_q <= sum;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q <= op_in;
          ch_q <= character_i;
          if (op_in == OP_INSERT || op_in == OP_PASTE) begin
            amt_q <= ins_amt;
            ovf_q <= ins_ovf;
            idx_q <= (text_cnt_q > cursor_q) ? text_cnt_q - CW'(1) : '0;
          end else begin
            amt_q <= take;
            ovf_q <= 1'b0;
            idx_q <= '0;
          end
        end
      end
      S_SHR_WR:   idx_q <= (idx_q == cursor_q) ? '0 : idx_q - CW'(1);
      S_FILL_WR:  idx_q <= idx_inc;
      S_GRAB_WR:  idx_q <= grab_last ? cursor_q : idx_inc;
      S_SHL_WR:   idx_q <= idx_inc;
      S_READ_OUT: begin
        if (buf_ready_i) idx_q <= idx_inc;
      end
      default: ;
    endcase
  end

  // text store, registered read
  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= text_wdata;
    end
    text_rdata_q <= text_mem[text_raddr];
  end

  // clipboard store, registered read
  always_ff @(posedge clk_i) begin
    if (clip_we) begin
      clip_mem[clip_waddr] <= text_rdata_q;
    end
    clip_rdata_q <= clip_mem[clip_raddr];
  end

`ifndef NO_ASSERTIONS
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= text_cnt_q)
    else $error("cursor beyond end of text");
  a_text_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_cnt_q <= DEPTH_C)
    else $error("text length above capacity");
  a_clip_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_cnt_q <= DEPTH_C)
    else $error("clipboard length above capacity");
  a_read_keeps_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ_OUT) |=> $stable(text_cnt_q) && $stable(cursor_q))
    else $error("text changed during read stream");
  a_left_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_in == OP_LEFT) |=>
      ((cursor_q + CW'(1)) == $past(cursor_q)) ||
      ($past(cursor_q) == '0 && cursor_q == '0))
    else $error("left move went wrong");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/cursor_text_buffer_editor_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cursor_text_buffer_editor_top
// Bounded text buffer with cursor and clipboard, driven by edit commands.
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  command  | in_valid_i / in_ready_o     | opcode_i, character_i, count_i
//  result   | out_valid_o / out_ready_i   | is_char_o, out_char_o, last_o,
//           |                             | text_length_o, cursor_pos_o,
//           |                             | overflow_o
//
//  One command at a time. Moves go straight to the status transfer.
//  Insert and paste shift the tail right and write the inserted bytes,
//  cut and copy grab the taken bytes (and cut shifts the tail left), read
//  streams every byte (a status result when empty): the text store, with
//  one write port and one registered read port, reads then writes each byte.
//  Reset clears length, cursor and clipboard length; store contents are
//  not cleared. A stalled result holds in the output register and the
//  sequencer waits behind it.
// ---------------------------------------------------------------------------
module cursor_text_buffer_editor_top
  import ctbe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    opcode_i,
  input  wire logic [7:0]    character_i,
  input  wire logic [CW-1:0] count_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               is_char_o,
  output logic [7:0]         out_char_o,
  output logic               last_o,
  output logic [CW-1:0]      text_length_o,
  output logic [CW-1:0]      cursor_pos_o,
  output logic               overflow_o
);

  logic    push;
  logic    buf_ready;
  result_t res;
  result_t res_out;

  // command sequencer and stores
  ctbe_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .character_i (character_i),
    .count_i     (count_i),
    .buf_ready_i (buf_ready),
    .push_o      (push),
    .res_o       (res)
  );

  // result register
  ctbe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign is_char_o     = res_out.is_char;
  assign out_char_o    = res_out.out_char;
  assign last_o        = res_out.last;
  assign text_length_o = res_out.text_length;
  assign cursor_pos_o  = res_out.cursor_pos;
  assign overflow_o    = res_out.overflow;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor text buffer editor. Commands are sent
// over the valid/ready command channel. A behavioral copy of the text, the
// cursor and the clipboard predicts every result. Each result transfer is
// compared field by field with the oldest prediction. Both sides idle at
// random, and one long receiver stall fills the block.
// ---------------------------------------------------------------------------
module tb;
  import ctbe_pkg::*;

  // code outside the defined command set
  localparam logic [2:0] OP_SPARE = 3'd7;
  // settle time after the last result, above the slowest command
  localparam int unsigned SETTLE_CYCLES = 300;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [2:0]    opcode_i    = OP_LEFT;
  logic [7:0]    character_i = 8'h00;
  logic [CW-1:0] count_i     = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic          is_char_o;
  logic [7:0]    out_char_o;
  logic          last_o;
  logic [CW-1:0] text_length_o;
  logic [CW-1:0] cursor_pos_o;
  logic          overflow_o;

  // idle rates in percent and the long receiver stall
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold     = 0;
  int unsigned err_cnt     = 0;

  // shadow copy of the editor
  logic [7:0] text_buf [TEXT_DEPTH];
  logic [7:0] clip_buf [TEXT_DEPTH];
  int         shadow_len = 0;
  int         cur_pos    = 0;
  int         clip_len   = 0;

  // results still owed by the block, oldest first
  result_t pending_results[$];

  cursor_text_buffer_editor_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .character_i  (character_i),
    .count_i      (count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_char_o    (is_char_o),
    .out_char_o   (out_char_o),
    .last_o       (last_o),
    .text_length_o(text_length_o),
    .cursor_pos_o (cursor_pos_o),
    .overflow_o   (overflow_o)
  );

  // clock
  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // receiver ready, with random idling and an optional long stall
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // queue one expected result from the current shadow state
  function automatic void push_result(logic is_chr, logic [7:0] chr, logic lst, logic ovf);
    result_t r;
    r.is_char     = is_chr;
    r.out_char    = chr;
    r.last        = lst;
    r.text_length = shadow_len[CW-1:0];
    r.cursor_pos  = cur_pos[CW-1:0];
    r.overflow    = ovf;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // one byte before the cursor; 0 when the text is full
  function automatic bit insert_char(logic [7:0] chr);
    int i;
    if (shadow_len >= TEXT_DEPTH) return 1'b0;
    for (i = shadow_len; i > cur_pos; i--) text_buf[i] = text_buf[i-1];
    text_buf[cur_pos] = chr;
    shadow_len++;
    cur_pos++;
    return 1'b1;
  endfunction

  // apply one command to the shadow state and queue its results
  function automatic void apply_edit(logic [2:0] op, logic [7:0] chr, logic [CW-1:0] cnt);
    int take;
    int i;
    bit ovf;
    ovf = 1'b0;
    case (op)
      OP_LEFT: begin
        if (cur_pos > 0) cur_pos--;
      end
      OP_RIGHT: begin
        if (cur_pos < shadow_len) cur_pos++;
      end
      OP_INSERT: begin
        ovf = !insert_char(chr);
      end
      OP_CUT, OP_COPY: begin
        take = shadow_len - cur_pos;
        if (cnt < take) take = cnt;
        for (i = 0; i < take; i++) clip_buf[i] = text_buf[cur_pos+i];
        clip_len = take;
        if (op == OP_CUT) begin
          for (i = cur_pos; i + take < shadow_len; i++) text_buf[i] = text_buf[i+take];
          shadow_len -= take;
        end
      end
      OP_PASTE: begin
        for (i = 0; i < clip_len && !ovf; i++) ovf = !insert_char(clip_buf[i]);
      end
      OP_READ: begin
        if (shadow_len == 0) begin
          push_result(1'b0, 8'h00, 1'b1, 1'b0);
        end else begin
          for (i = 0; i < shadow_len; i++)
            push_result(1'b1, text_buf[i], (i == shadow_len - 1), 1'b0);
        end
        return;
      end
      default: begin
      end
    endcase
    push_result(1'b0, 8'h00, 1'b1, ovf);
  endfunction

  // one field of a result
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.is_char     = is_char_o;
      got.out_char    = out_char_o;
      got.last        = last_o;
      got.text_length = text_length_o;
      got.cursor_pos  = cursor_pos_o;
      got.overflow    = overflow_o;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_char", want.is_char, got.is_char);
        check_field("out_char", want.out_char, got.out_char);
        check_field("last", want.last, got.last);
        check_field("text_length", want.text_length, got.text_length);
        check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
        check_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  // offer one command and predict it once transferred
  task automatic send_edit(input logic [2:0] op, input logic [7:0] chr,
                           input logic [CW-1:0] cnt);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    character_i <= chr;
    count_i     <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    apply_edit(op, chr, cnt);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // random command, leaning toward cuts when the text is nearly full
  function automatic logic [2:0] pick_edit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (shadow_len >= TEXT_DEPTH - 4 && r < 30) return OP_CUT;
    if (r < 18) return OP_LEFT;
    if (r < 30) return OP_RIGHT;
    if (r < 55) return OP_INSERT;
    if (r < 63) return OP_CUT;
    if (r < 72) return OP_COPY;
    if (r < 86) return OP_PASTE;
    return OP_READ;
  endfunction

  // commands on an empty text and clipboard
  task automatic test_empty_text();
    send_edit(OP_READ, 8'h00, '0);
    send_edit(OP_SPARE, 8'hFF, 7'd64);
    send_edit(OP_RIGHT, 8'h00, '0);
    send_edit(OP_LEFT, 8'h00, '0);
    send_edit(OP_COPY, 8'h00, '0);
    send_edit(OP_PASTE, 8'h00, '0);
  endtask

  // fill through repeated pastes until the text overflows
  task automatic test_fill_overflow();
    logic [7:0] seed_chars [7];
    int i;
    seed_chars = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55};
    for (i = 0; i < 7; i++) send_edit(OP_INSERT, seed_chars[i], '0);
    // back to the start, one step past it
    for (i = 0; i < 8; i++) send_edit(OP_LEFT, 8'h00, '0);
    send_edit(OP_COPY, 8'h00, 7'd64);
    // last paste fits only partly
    for (i = 0; i < 9; i++) send_edit(OP_PASTE, 8'h00, '0);
    send_edit(OP_INSERT, 8'hAA, '0);
    send_edit(OP_READ, 8'h00, '0);
  endtask

  // random commands with random content
  task automatic test_random(input int unsigned n);
    int unsigned k;
    logic [CW-1:0] cnt;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) cnt = CW'($urandom_range(0, 64));
      else cnt = CW'($urandom_range(0, 8));
      send_edit(pick_edit(), 8'($urandom_range(0, 255)), cnt);
    end
  endtask

  // long receiver stall while commands keep coming
  task automatic test_backpressure();
    rx_hold = 400;
    test_random(12);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 27;
    rx_idle_pct = 86;
    test_empty_text();
    test_fill_overflow();
    test_random(120);
    wait_drained();

    tx_idle_pct = 86;
    rx_idle_pct = 27;
    test_random(130);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random(85);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
